// ===== hw/rtl/vector3_alu_assert.svh =====
`ifndef VECTOR3_ALU_ASSERT_SVH
`define VECTOR3_ALU_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define V3_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vector3_alu: assertion failed");

// Next-cycle implication.
`define V3_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vector3_alu: assertion failed");

`endif

// ===== hw/rtl/v3alu_pkg.sv =====
package v3alu_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int OP_BITS   = 4;
   localparam int EPS_BITS  = 31;
   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam int WIDE_BITS = 2 * WORD_BITS + 2;
   localparam int CMP_BITS  = (WORD_BITS + 1 > EPS_BITS) ? WORD_BITS + 1 : EPS_BITS;

   localparam logic [EPS_BITS-1:0] EPS_RESET = EPS_BITS'(66);

   localparam logic signed [WIDE_BITS-1:0] WIDE_MAX =
      $signed((WIDE_BITS'(1) << (WORD_BITS - 1)) - WIDE_BITS'(1));
   localparam logic signed [WIDE_BITS-1:0] WIDE_MIN = -WIDE_MAX - WIDE_BITS'(1);
   localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS - 1){1'b1}}};
   localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS - 1){1'b0}}};

   typedef enum logic [OP_BITS-1:0] {
      OP_ADD       = 4'd0,
      OP_SUB       = 4'd1,
      OP_SCALE     = 4'd2,
      OP_DOT       = 4'd3,
      OP_CROSS_LH  = 4'd4,
      OP_CROSS_RH  = 4'd5,
      OP_LEN_SQ    = 4'd6,
      OP_LEN       = 4'd7,
      OP_NORMALIZE = 4'd8,
      OP_EQUALS    = 4'd9
   } op_type;

   typedef logic signed [WORD_BITS-1:0] word_type;

   typedef struct packed {
      logic [OP_BITS-1:0]          operation;
      logic signed [WORD_BITS-1:0] a_x;
      logic signed [WORD_BITS-1:0] a_y;
      logic signed [WORD_BITS-1:0] a_z;
      logic signed [WORD_BITS-1:0] b_x;
      logic signed [WORD_BITS-1:0] b_y;
      logic signed [WORD_BITS-1:0] b_z;
      logic signed [WORD_BITS-1:0] scale_factor;
   } req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] res_x;
      logic signed [WORD_BITS-1:0] res_y;
      logic signed [WORD_BITS-1:0] res_z;
      logic signed [WORD_BITS-1:0] res_scalar;
      logic                        flag;
      logic                        overflow;
   } rsp_type;

   // What one lane hands to the merge stage.
   typedef struct packed {
      logic signed [PROD_BITS-1:0] p_main;
      logic signed [PROD_BITS-1:0] p_c1;
      logic signed [PROD_BITS-1:0] p_c2;
      logic signed [WORD_BITS:0]   sum;
      logic signed [WORD_BITS:0]   diff;
      logic                        eq_ok;
      word_type                    a;
   } lane_type;

   // Merged result before the root and quotient are known.
   typedef struct packed {
      op_type                 op;
      word_type [2:0]         vec;
      word_type               scalar;
      logic                   flag;
      logic                   ovf;
      logic [PROD_BITS-1:0]   sq;
      word_type [2:0]         a;
   } pre_type;

   typedef struct packed {
      word_type val;
      logic     ovf;
   } sat_type;

   function automatic sat_type saturate(input logic signed [WIDE_BITS-1:0] v);
      sat_type r;
      r.ovf = 1'b0;
      r.val = v[WORD_BITS-1:0];
      if (v > WIDE_MAX) begin
         r.ovf = 1'b1;
         r.val = WORD_MAX;
      end else if (v < WIDE_MIN) begin
         r.ovf = 1'b1;
         r.val = WORD_MIN;
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/vector3_alu.sv =====
// 3D vector unit in signed fixed point (WORD_BITS-bit words, FRAC_BITS fraction
// bits; Q16.16 by default). It takes a transaction on every clock (busy stays
// low) and returns its result on rsp_data with a one-cycle rsp_valid strobe,
// in order, for every operation. The result passes through the square-root
// pipeline (one root bit per stage) followed by the normalize dividers (one
// quotient bit per stage); the other operations travel alongside. There is no
// backpressure: the receiver must take each result in the cycle it is shown.
// Write epsilon through csr_* only while no transaction is in flight.
`include "vector3_alu_assert.svh"

module vector3_alu #(
   parameter int FRAC_BITS = v3alu_pkg::FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  v3alu_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   output v3alu_pkg::rsp_type                  rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [v3alu_pkg::EPS_BITS-1:0]      csr_data
);

   localparam int W   = v3alu_pkg::WORD_BITS;
   localparam int NB  = W + FRAC_BITS;
   localparam int DLY = W + NB;
   localparam int LAT = W + NB + 3;

   logic [v3alu_pkg::EPS_BITS-1:0] eps_ff;
   logic [LAT-1:0]                 vld_ff;
   v3alu_pkg::op_type              op_a_ff;
   v3alu_pkg::word_type            a_vec [3];
   v3alu_pkg::word_type            b_vec [3];
   v3alu_pkg::lane_type            lane_ff [3];
   v3alu_pkg::pre_type             pre_ff;
   v3alu_pkg::pre_type             pre_dly_ff [DLY];
   v3alu_pkg::pre_type             pre_q;
   logic [W-1:0]                   root;
   logic [W-1:0]                   len_dly_ff [NB];
   logic [W-1:0]                   len_q;
   logic [W-1:0]                   mag [3];
   logic [NB-1:0]                  quo [3];
   v3alu_pkg::rsp_type             rsp_in;
   v3alu_pkg::rsp_type             rsp_ff;
   v3alu_pkg::word_type            vec_out [3];
   logic                           accept;
   logic                           nrm_ov;
   logic                           lane_ov;
   logic [W-1:0]                   q_lo;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= v3alu_pkg::EPS_RESET;
         vld_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            eps_ff <= csr_data;
         end
         vld_ff <= {vld_ff[LAT-2:0], accept};
      end
   end

   assign a_vec[0] = req_data.a_x;
   assign a_vec[1] = req_data.a_y;
   assign a_vec[2] = req_data.a_z;
   assign b_vec[0] = req_data.b_x;
   assign b_vec[1] = req_data.b_y;
   assign b_vec[2] = req_data.b_z;

   always_ff @(posedge clock) begin
      op_a_ff <= v3alu_pkg::op_type'(req_data.operation);
   end

   for (genvar i = 0; i < 3; i++) begin : g_lane
      localparam int J = (i + 1) % 3;
      localparam int K = (i + 2) % 3;
      v3alu_lane u_lane (
         .clock   (clock),
         .op      (v3alu_pkg::op_type'(req_data.operation)),
         .a_i     (a_vec[i]),
         .b_i     (b_vec[i]),
         .a_j     (a_vec[J]),
         .a_k     (a_vec[K]),
         .b_j     (b_vec[J]),
         .b_k     (b_vec[K]),
         .s       (req_data.scale_factor),
         .eps     (eps_ff),
         .lane_ff (lane_ff[i])
      );
   end

   v3alu_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
      .clock  (clock),
      .op     (op_a_ff),
      .lanes  (lane_ff),
      .pre_ff (pre_ff)
   );

   v3alu_sqrt u_sqrt (
      .clock    (clock),
      .radicand (pre_ff.sq),
      .root     (root)
   );

   // Carry the merged result alongside the root and quotient pipelines.
   always_ff @(posedge clock) begin
      pre_dly_ff[0] <= pre_ff;
      for (int m = 1; m < DLY; m++) begin
         pre_dly_ff[m] <= pre_dly_ff[m-1];
      end
      len_dly_ff[0] <= root;
      for (int m = 1; m < NB; m++) begin
         len_dly_ff[m] <= len_dly_ff[m-1];
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_div
      assign mag[i] = pre_dly_ff[W-1].a[i][W-1] ? W'(-pre_dly_ff[W-1].a[i])
                                                 : W'(pre_dly_ff[W-1].a[i]);
      v3alu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
         .clock (clock),
         .mag   (mag[i]),
         .den   (root),
         .quo   (quo[i])
      );
   end

   assign pre_q = pre_dly_ff[DLY-1];
   assign len_q = len_dly_ff[NB-1];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vec_out[i] = pre_q.vec[i];
      end
      rsp_in.res_scalar = pre_q.scalar;
      rsp_in.flag       = pre_q.flag;
      rsp_in.overflow   = pre_q.ovf;
      nrm_ov            = 1'b0;
      lane_ov           = 1'b0;
      q_lo              = '0;

      case (pre_q.op)
         v3alu_pkg::OP_LEN: begin
            rsp_in.res_scalar = len_q[W-1] ? v3alu_pkg::WORD_MAX : len_q;
            rsp_in.overflow   = len_q[W-1];
         end
         v3alu_pkg::OP_NORMALIZE: begin
            // zero vector: keep the (all-zero) input, flag stays clear
            if (len_q != '0) begin
               for (int i = 0; i < 3; i++) begin
                  q_lo = quo[i][W-1:0];
                  if (!pre_q.a[i][W-1]) begin
                     lane_ov    = |quo[i][NB-1:W-1];
                     vec_out[i] = lane_ov ? v3alu_pkg::WORD_MAX : q_lo;
                  end else begin
                     lane_ov    = (|quo[i][NB-1:W]) || (q_lo[W-1] && (|q_lo[W-2:0]));
                     vec_out[i] = lane_ov ? v3alu_pkg::WORD_MIN : W'(-q_lo);
                  end
                  nrm_ov = nrm_ov | lane_ov;
               end
               rsp_in.flag     = 1'b1;
               rsp_in.overflow = nrm_ov;
            end
         end
         default: begin
         end
      endcase

      rsp_in.res_x = vec_out[0];
      rsp_in.res_y = vec_out[1];
      rsp_in.res_z = vec_out[2];
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = vld_ff[LAT-1];
   assign rsp_data  = rsp_ff;

   `V3_ASSERT_NOW(a_flag_no_scalar, clock, reset, rsp_valid && rsp_data.flag,
                  rsp_data.res_scalar == '0)
   `V3_ASSERT_NOW(a_rsp_has_req, clock, reset, rsp_valid, $past(accept, LAT))
   `V3_ASSERT_NEXT(a_csr_write, clock, reset, csr_valid && csr_ready,
                   eps_ff == $past(csr_data))

endmodule

// ===== hw/rtl/v3alu_lane.sv =====
module v3alu_lane (
   input  logic                                   clock,
   input  v3alu_pkg::op_type                      op,
   input  v3alu_pkg::word_type                    a_i,
   input  v3alu_pkg::word_type                    b_i,
   input  v3alu_pkg::word_type                    a_j,
   input  v3alu_pkg::word_type                    a_k,
   input  v3alu_pkg::word_type                    b_j,
   input  v3alu_pkg::word_type                    b_k,
   input  v3alu_pkg::word_type                    s,
   input  logic [v3alu_pkg::EPS_BITS-1:0]         eps,
   output v3alu_pkg::lane_type                    lane_ff
);

   localparam int W  = v3alu_pkg::WORD_BITS;
   localparam int PB = v3alu_pkg::PROD_BITS;
   localparam int CB = v3alu_pkg::CMP_BITS;

   v3alu_pkg::word_type  mult_sel;
   v3alu_pkg::lane_type  lane_in;
   logic signed [PB-1:0] ax, mx, aj, ak, bj, bk;
   logic signed [W:0]    d;
   logic [W:0]           d_mag;

   always_comb begin
      case (op)
         v3alu_pkg::OP_SCALE:     mult_sel = s;
         v3alu_pkg::OP_LEN_SQ,
         v3alu_pkg::OP_LEN,
         v3alu_pkg::OP_NORMALIZE: mult_sel = a_i;
         default:                 mult_sel = b_i;
      endcase
   end

   always_comb begin
      ax = PB'(a_i);
      mx = PB'(mult_sel);
      aj = PB'(a_j);
      ak = PB'(a_k);
      bj = PB'(b_j);
      bk = PB'(b_k);
      d  = (W+1)'(a_i) - (W+1)'(b_i);
      d_mag = d[W] ? (W+1)'(-d) : (W+1)'(d);

      lane_in.p_main = ax * mx;
      lane_in.p_c1   = bj * ak;
      lane_in.p_c2   = bk * aj;
      lane_in.sum    = (W+1)'(a_i) + (W+1)'(b_i);
      lane_in.diff   = d;
      lane_in.eq_ok  = CB'(d_mag) < CB'(eps);
      lane_in.a      = a_i;
   end

   always_ff @(posedge clock) begin
      lane_ff <= lane_in;
   end

endmodule

// ===== hw/rtl/v3alu_merge.sv =====
module v3alu_merge #(
   parameter int FRAC_BITS = v3alu_pkg::FRAC_BITS
) (
   input  logic                 clock,
   input  v3alu_pkg::op_type    op,
   input  v3alu_pkg::lane_type  lanes [3],
   output v3alu_pkg::pre_type   pre_ff
);

   localparam int PB = v3alu_pkg::PROD_BITS;
   localparam int XB = v3alu_pkg::WIDE_BITS;

   logic signed [XB-1:0] dot_sum, dot_fl;
   logic signed [XB-1:0] cr_d [3];
   logic signed [XB-1:0] sel_w [3];
   v3alu_pkg::sat_type   vec_sat [3];
   v3alu_pkg::sat_type   scl_sat;
   v3alu_pkg::pre_type   pre_in;
   logic                 vec_ov;
   logic                 eq_all;

   always_comb begin
      dot_sum = XB'(lanes[0].p_main) + XB'(lanes[1].p_main) + XB'(lanes[2].p_main);
      dot_fl  = dot_sum >>> FRAC_BITS;
      scl_sat = v3alu_pkg::saturate(dot_fl);
      vec_ov  = 1'b0;
      eq_all  = 1'b1;
      for (int i = 0; i < 3; i++) begin
         cr_d[i] = XB'(lanes[i].p_c1) - XB'(lanes[i].p_c2);
         case (op)
            v3alu_pkg::OP_ADD:      sel_w[i] = XB'(lanes[i].sum);
            v3alu_pkg::OP_SUB:      sel_w[i] = XB'(lanes[i].diff);
            v3alu_pkg::OP_SCALE:    sel_w[i] = XB'(lanes[i].p_main) >>> FRAC_BITS;
            v3alu_pkg::OP_CROSS_LH: sel_w[i] = cr_d[i] >>> FRAC_BITS;
            v3alu_pkg::OP_CROSS_RH: sel_w[i] = (-cr_d[i]) >>> FRAC_BITS;
            default:                sel_w[i] = '0;
         endcase
         vec_sat[i] = v3alu_pkg::saturate(sel_w[i]);
         vec_ov     = vec_ov | vec_sat[i].ovf;
         eq_all     = eq_all & lanes[i].eq_ok;
      end

      pre_in.op     = op;
      pre_in.vec    = '0;
      pre_in.scalar = '0;
      pre_in.flag   = 1'b0;
      pre_in.ovf    = 1'b0;
      pre_in.sq     = dot_sum[PB-1:0];
      for (int i = 0; i < 3; i++) begin
         pre_in.a[i] = lanes[i].a;
      end

      case (op)
         v3alu_pkg::OP_ADD,
         v3alu_pkg::OP_SUB,
         v3alu_pkg::OP_SCALE,
         v3alu_pkg::OP_CROSS_LH,
         v3alu_pkg::OP_CROSS_RH: begin
            for (int i = 0; i < 3; i++) begin
               pre_in.vec[i] = vec_sat[i].val;
            end
            pre_in.ovf = vec_ov;
         end
         v3alu_pkg::OP_DOT,
         v3alu_pkg::OP_LEN_SQ: begin
            pre_in.scalar = scl_sat.val;
            pre_in.ovf    = scl_sat.ovf;
         end
         v3alu_pkg::OP_EQUALS: begin
            pre_in.flag = eq_all;
         end
         default: begin
            // length and normalize finish after the root stage
         end
      endcase
   end

   always_ff @(posedge clock) begin
      pre_ff <= pre_in;
   end

endmodule

// ===== hw/rtl/v3alu_sqrt.sv =====
module v3alu_sqrt (
   input  logic                                 clock,
   input  logic [2*v3alu_pkg::WORD_BITS-1:0]    radicand,
   output logic [v3alu_pkg::WORD_BITS-1:0]      root
);

   localparam int W  = v3alu_pkg::WORD_BITS;
   localparam int RB = 2 * W;

   logic [RB-1:0] rad_src [W];
   logic [W:0]    rem_src [W];
   logic [W-1:0]  root_src [W];
   logic [RB-1:0] rad_in [W];
   logic [W:0]    rem_in [W];
   logic [W-1:0]  root_in [W];
   logic [RB-1:0] rad_ff [W];
   logic [W:0]    rem_ff [W];
   logic [W-1:0]  root_ff [W];

   // One root bit per stage, two radicand bits consumed per stage.
   for (genvar k = 0; k < W; k++) begin : g_step
      logic [W+2:0] rs;
      logic [W+2:0] trial;

      if (k == 0) begin : g_first
         assign rad_src[k]  = radicand;
         assign rem_src[k]  = '0;
         assign root_src[k] = '0;
      end else begin : g_next
         assign rad_src[k]  = rad_ff[k-1];
         assign rem_src[k]  = rem_ff[k-1];
         assign root_src[k] = root_ff[k-1];
      end

      always_comb begin
         rs        = {rem_src[k], rad_src[k][RB-1 -: 2]};
         trial     = {1'b0, root_src[k], 2'b01};
         rad_in[k] = rad_src[k] << 2;
         if (rs >= trial) begin
            rem_in[k]  = (W+1)'(rs - trial);
            root_in[k] = {root_src[k][W-2:0], 1'b1};
         end else begin
            rem_in[k]  = rs[W:0];
            root_in[k] = {root_src[k][W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         rad_ff[k]  <= rad_in[k];
         rem_ff[k]  <= rem_in[k];
         root_ff[k] <= root_in[k];
      end
   end

   assign root = root_ff[W-1];

endmodule

// ===== hw/rtl/v3alu_div.sv =====
module v3alu_div #(
   parameter int FRAC_BITS = v3alu_pkg::FRAC_BITS
) (
   input  logic                                           clock,
   input  logic [v3alu_pkg::WORD_BITS-1:0]                mag,
   input  logic [v3alu_pkg::WORD_BITS-1:0]                den,
   output logic [v3alu_pkg::WORD_BITS+FRAC_BITS-1:0]      quo
);

   localparam int W  = v3alu_pkg::WORD_BITS;
   localparam int NB = W + FRAC_BITS;

   logic [NB-1:0] num_src [NB];
   logic [W-1:0]  rem_src [NB];
   logic [NB-1:0] quo_src [NB];
   logic [W-1:0]  den_src [NB];
   logic [NB-1:0] num_in [NB];
   logic [W-1:0]  rem_in [NB];
   logic [NB-1:0] quo_in [NB];
   logic [NB-1:0] num_ff [NB];
   logic [W-1:0]  rem_ff [NB];
   logic [NB-1:0] quo_ff [NB];
   logic [W-1:0]  den_ff [NB];

   // Restoring division, one quotient bit per stage.
   for (genvar k = 0; k < NB; k++) begin : g_step
      logic [W:0] r2;
      logic [W:0] dx;

      if (k == 0) begin : g_first
         assign num_src[k] = {mag, {FRAC_BITS{1'b0}}};
         assign rem_src[k] = '0;
         assign quo_src[k] = '0;
         assign den_src[k] = den;
      end else begin : g_next
         assign num_src[k] = num_ff[k-1];
         assign rem_src[k] = rem_ff[k-1];
         assign quo_src[k] = quo_ff[k-1];
         assign den_src[k] = den_ff[k-1];
      end

      always_comb begin
         r2        = {rem_src[k], num_src[k][NB-1]};
         dx        = {1'b0, den_src[k]};
         num_in[k] = num_src[k] << 1;
         if (r2 >= dx) begin
            rem_in[k] = W'(r2 - dx);
            quo_in[k] = {quo_src[k][NB-2:0], 1'b1};
         end else begin
            rem_in[k] = r2[W-1:0];
            quo_in[k] = {quo_src[k][NB-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         num_ff[k] <= num_in[k];
         rem_ff[k] <= rem_in[k];
         quo_ff[k] <= quo_in[k];
         den_ff[k] <= den_src[k];
      end
   end

   assign quo = quo_ff[NB-1];

endmodule
